[rtl/rotenc_pkg.sv]
`timescale 1ns / 1ps

package rotenc_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int TURNS_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int SPD_W       = 4;
    localparam int DEB_W       = 8;
    localparam int ACC_W       = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEPS_PER_DETENT   = 2'd0,
        REG_DEBOUNCE_TICKS     = 2'd1,
        REG_SWITCH_ACTIVE_HIGH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SPD_W-1:0] steps_per_detent;
        logic [DEB_W-1:0] debounce_ticks;
        logic             switch_active_high;
    } cfg_t;

    localparam logic [SPD_W-1:0] STEPS_RESET    = 4'd4;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd20;
    localparam logic [1:0]       AB_IDLE        = 2'b11;

    // index is {previous ab, current ab}
    localparam logic signed [1:0] GRAY_STEP [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

endpackage

[rtl/rotary_encoder_with_switch_top.sv]
`timescale 1ns / 1ps

// Quadrature encoder and push-switch front end. One input word is one sample tick of the
// A/B pins and the raw switch, and each word yields exactly one result word. A word passes
// through an input register and then an output register before its result is presented;
// a new word can be taken every cycle while results are taken as they come, and while a
// result waits at the output one further word is held in the input register. The rate is
// set by the combinational decode and debounce update of the running state. Turn count
// and press latch are cleared after being reported when clear_turns and take_press are
// set. Configuration is taken every cycle and must only be written while the block is
// idle.
module rotary_encoder_with_switch_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 pin_a,
    input  logic                                 pin_b,
    input  logic                                 switch_pin,
    input  logic                                 clear_turns,
    input  logic                                 take_press,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rotenc_pkg::TURNS_W-1:0] turns_pending,
    output logic                                 press_pending,
    output logic                                 switch_level,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rotenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rotenc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rotenc_pkg::*;

    cfg_t               cfg;
    logic               s1_valid_reg;
    logic               a_reg;
    logic               b_reg;
    logic               sw_reg;
    logic               take_t_reg;
    logic               take_p_reg;
    logic               out_valid_reg;
    logic [TURNS_W-1:0] turns_reg;
    logic               press_reg;
    logic               level_reg;
    logic               out_free;
    logic               advance;
    logic [TURNS_W-1:0] turns_w;
    logic               press_w;
    logic               level_w;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    rotenc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rotenc_quad u_quad (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .pin_a       (a_reg),
        .pin_b       (b_reg),
        .clear_turns (take_t_reg),
        .cfg         (cfg),
        .turns       (turns_w)
    );

    rotenc_switch u_switch (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .switch_pin (sw_reg),
        .take_press (take_p_reg),
        .cfg        (cfg),
        .press      (press_w),
        .level      (level_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_reg      <= pin_a;
            b_reg      <= pin_b;
            sw_reg     <= switch_pin;
            take_t_reg <= clear_turns;
            take_p_reg <= take_press;
        end
        if (advance)
        begin
            turns_reg <= turns_w;
            press_reg <= press_w;
            level_reg <= level_w;
        end
    end

    assign out_valid     = out_valid_reg;
    assign turns_pending = signed'(turns_reg);
    assign press_pending = press_reg;
    assign switch_level  = level_reg;

endmodule

[rtl/rotenc_cfg.sv]
`timescale 1ns / 1ps

module rotenc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rotenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rotenc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rotenc_pkg::cfg_t                     cfg
);
    import rotenc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEPS_PER_DETENT:   cfg_next.steps_per_detent   = cfg_data[SPD_W-1:0];
                REG_DEBOUNCE_TICKS:     cfg_next.debounce_ticks     = cfg_data[DEB_W-1:0];
                REG_SWITCH_ACTIVE_HIGH: cfg_next.switch_active_high = cfg_data[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_detent   <= STEPS_RESET;
            cfg_reg.debounce_ticks     <= DEBOUNCE_RESET;
            cfg_reg.switch_active_high <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/rotenc_quad.sv]
`timescale 1ns / 1ps

module rotenc_quad (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              pin_a,
    input  logic                              pin_b,
    input  logic                              clear_turns,
    input  rotenc_pkg::cfg_t                  cfg,
    output logic [rotenc_pkg::TURNS_W-1:0]    turns
);
    import rotenc_pkg::*;

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    logic [1:0]                    prev_ab_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       acc_sum;
    logic signed [ACC_W-1:0]       spd;
    logic signed [COUNT_WIDTH-1:0] count_reg;
    logic signed [COUNT_WIDTH-1:0] count_upd;
    logic signed [COUNT_WIDTH-1:0] count_next;
    logic [1:0]                    ab;

    assign ab = {pin_a, pin_b};

    always_comb
    begin
        // zero steps per detent behaves as one
        if (cfg.steps_per_detent == '0)
            spd = ACC_W'(1);
        else
            spd = signed'(ACC_W'(cfg.steps_per_detent));

        acc_sum   = acc_reg + ACC_W'(GRAY_STEP[{prev_ab_reg, ab}]);
        acc_next  = acc_sum;
        count_upd = count_reg;
        if (acc_sum >= spd)
        begin
            acc_next = acc_sum - spd;
            if (count_reg != CNT_MAX)
                count_upd = count_reg + COUNT_WIDTH'(1);
        end
        else if (acc_sum <= -spd)
        begin
            acc_next = acc_sum + spd;
            if (count_reg != CNT_MIN)
                count_upd = count_reg - COUNT_WIDTH'(1);
        end

        count_next = clear_turns ? '0 : count_upd;
    end

    assign turns = TURNS_W'(count_upd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg <= AB_IDLE;
            acc_reg     <= '0;
            count_reg   <= '0;
        end
        else if (advance)
        begin
            prev_ab_reg <= ab;
            acc_reg     <= acc_next;
            count_reg   <= count_next;
        end
    end

endmodule

[rtl/rotenc_switch.sv]
`timescale 1ns / 1ps

module rotenc_switch (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             switch_pin,
    input  logic             take_press,
    input  rotenc_pkg::cfg_t cfg,
    output logic             press,
    output logic             level
);
    import rotenc_pkg::*;

    logic             cand_reg;
    logic             cand_next;
    logic             stable_reg;
    logic             stable_next;
    logic [DEB_W-1:0] elapsed_reg;
    logic [DEB_W-1:0] elapsed_next;
    logic             press_reg;
    logic             press_upd;
    logic             raw;

    always_comb
    begin
        raw          = cfg.switch_active_high ? switch_pin : ~switch_pin;
        cand_next    = cand_reg;
        elapsed_next = elapsed_reg;
        if (raw != cand_reg)
        begin
            cand_next    = raw;
            elapsed_next = '0;
        end
        else if (elapsed_reg != '1)
        begin
            elapsed_next = elapsed_reg + DEB_W'(1);
        end

        stable_next = stable_reg;
        press_upd   = press_reg;
        if (cand_next != stable_reg && elapsed_next >= cfg.debounce_ticks)
        begin
            // released-to-pressed edge latches a press
            if (!stable_reg && cand_next)
                press_upd = 1'b1;
            stable_next = cand_next;
        end
    end

    assign press = press_upd;
    assign level = stable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg    <= 1'b0;
            stable_reg  <= 1'b0;
            elapsed_reg <= '0;
            press_reg   <= 1'b0;
        end
        else if (advance)
        begin
            cand_reg    <= cand_next;
            stable_reg  <= stable_next;
            elapsed_reg <= elapsed_next;
            press_reg   <= press_upd & ~take_press;
        end
    end

endmodule

[rtl/rotenc_chk.sv]
`timescale 1ns / 1ps

module rotenc_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [rotenc_pkg::TURNS_W-1:0]    turns_pending
);

    // a stalled result word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(turns_pending))
        else $error("result word changed while stalled");

    // input back-pressure only when both stages hold a word
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output stage free");

    // a new result rises only after its word was taken and held in the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a taken input word");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result word dropped without handshake");

endmodule

bind rotary_encoder_with_switch_top rotenc_chk u_rotenc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .turns_pending (turns_pending)
);

[tb/rotary_encoder_with_switch_top_tb.sv]
`timescale 1ns / 1ps

module rotary_encoder_with_switch_top_tb;

    import rotenc_pkg::*;

    localparam int TURN_MAX = (1 << (COUNT_WIDTH - 1)) - 1;
    localparam int TURN_MIN = -TURN_MAX - 1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 2'd3;

    typedef struct packed {
        logic signed [TURNS_W-1:0] turns;
        logic                      press;
        logic                      level;
    } tick_report_t;

    class encoder_scoreboard;
        logic [SPD_W-1:0] steps_cfg;
        logic [DEB_W-1:0] debounce_cfg;
        logic             active_high_cfg;
        logic [1:0]       last_ab;
        int               step_sum;
        int               turn_total;
        logic             candidate;
        logic             stable;
        int               steady_ticks;
        logic             press_seen;
        tick_report_t     reports_due[$];
        int               mismatches;

        function new();
            steps_cfg       = STEPS_RESET;
            debounce_cfg    = DEBOUNCE_RESET;
            active_high_cfg = 1'b0;
            last_ab         = AB_IDLE;
            step_sum        = 0;
            turn_total      = 0;
            candidate       = 1'b0;
            stable          = 1'b0;
            steady_ticks    = 0;
            press_seen      = 1'b0;
            mismatches      = 0;
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        function void log_config(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STEPS_PER_DETENT:   steps_cfg = data[SPD_W-1:0];
                REG_DEBOUNCE_TICKS:     debounce_cfg = data[DEB_W-1:0];
                REG_SWITCH_ACTIVE_HIGH: active_high_cfg = data[0];
                default: ;
            endcase
        endfunction

        // decode one sample tick and queue the word it must produce
        function void log_tick(input logic [1:0] ab, input logic sw,
                               input logic tt, input logic tp);
            logic [1:0]   from_pos;
            logic [1:0]   to_pos;
            logic [1:0]   diff;
            int           span;
            logic         raw;
            tick_report_t word;

            // position along the gray cycle 00,01,11,10
            from_pos = {last_ab[1], last_ab[1] ^ last_ab[0]};
            to_pos   = {ab[1], ab[1] ^ ab[0]};
            diff     = to_pos - from_pos;
            if (diff == 2'd1)
                step_sum -= 1;
            else if (diff == 2'd3)
                step_sum += 1;
            last_ab = ab;

            span = (steps_cfg == 0) ? 1 : int'(steps_cfg);
            if (step_sum >= span) begin
                if (turn_total < TURN_MAX)
                    turn_total++;
                step_sum -= span;
            end else if (step_sum <= -span) begin
                if (turn_total > TURN_MIN)
                    turn_total--;
                step_sum += span;
            end

            raw = active_high_cfg ? sw : ~sw;
            if (raw != candidate) begin
                candidate    = raw;
                steady_ticks = 0;
            end else if (steady_ticks < 255) begin
                steady_ticks++;
            end
            if (candidate != stable && steady_ticks >= int'(debounce_cfg)) begin
                if (!stable && candidate)
                    press_seen = 1'b1;
                stable = candidate;
            end

            word.turns = turn_total[TURNS_W-1:0];
            word.press = press_seen;
            word.level = stable;
            reports_due.push_back(word);

            if (tt)
                turn_total = 0;
            if (tp)
                press_seen = 1'b0;
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= 100)
                $display("%0t: %s", $time, msg);
        endtask

        task check_result(input logic signed [TURNS_W-1:0] turns_got,
                          input logic press_got, input logic level_got);
            tick_report_t want;
            if (reports_due.size() == 0) begin
                report($sformatf("unexpected word turns=%0d press=%0b level=%0b",
                                 turns_got, press_got, level_got));
            end else begin
                want = reports_due.pop_front();
                if (turns_got !== want.turns)
                    report($sformatf("turns_pending got %0d want %0d", turns_got, want.turns));
                if (press_got !== want.press)
                    report($sformatf("press_pending got %0b want %0b", press_got, want.press));
                if (level_got !== want.level)
                    report($sformatf("switch_level got %0b want %0b", level_got, want.level));
            end
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      pin_a = 1'b1;
    logic                      pin_b = 1'b1;
    logic                      switch_pin = 1'b1;
    logic                      clear_turns = 1'b0;
    logic                      take_press = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [TURNS_W-1:0] turns_pending;
    logic                      press_pending;
    logic                      switch_level;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    encoder_scoreboard sb;
    logic [1:0] cur_ab = AB_IDLE;
    bit         in_calm = 1'b0;
    bit         out_calm = 1'b0;
    bit         spin_up = 1'b1;
    logic       sw_level = 1'b1;
    int         sw_left = 0;
    int         cur_debounce = 20;

    rotary_encoder_with_switch_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pin_a         (pin_a),
        .pin_b         (pin_b),
        .switch_pin    (switch_pin),
        .clear_turns   (clear_turns),
        .take_press    (take_press),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .turns_pending (turns_pending),
        .press_pending (press_pending),
        .switch_level  (switch_level),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // next pin pair one gray step along, up meaning a +1 step
    function automatic logic [1:0] ab_after(input logic [1:0] ab, input logic up);
        logic [1:0] pos;
        pos = {ab[1], ab[1] ^ ab[0]};
        pos = up ? pos - 2'd1 : pos + 2'd1;
        return {pos[1], pos[1] ^ pos[0]};
    endfunction

    // raw switch level in runs: short bounces and holds around the debounce length
    function automatic logic next_switch();
        if (sw_left == 0) begin
            sw_level = ~sw_level;
            if ($urandom_range(0, 2) == 0)
                sw_left = $urandom_range(1, 3);
            else
                sw_left = $urandom_range(cur_debounce > 20 ? cur_debounce - 20 : 1,
                                         cur_debounce + 12);
        end
        sw_left--;
        return sw_level;
    endfunction

    task automatic send_tick(input logic [1:0] ab, input logic sw,
                             input logic tt, input logic tp);
        int gap;
        if ($urandom_range(0, 31) == 0)
            in_calm = ~in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pin_a       <= ab[1];
        pin_b       <= ab[0];
        switch_pin  <= sw;
        clear_turns <= tt;
        take_press  <= tp;
        do @(posedge clk); while (!in_ready);
        sb.log_tick(ab, sw, tt, tp);
        cur_ab = ab;
    endtask

    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.log_config(idx, data);
    endtask

    // unused data bits are random, and the spare index is written as well
    task automatic set_config(input logic [SPD_W-1:0] spd, input logic [DEB_W-1:0] deb,
                              input logic ah);
        logic [CFG_DATA_W-1:0] noise;
        wait_drained();
        noise = CFG_DATA_W'($urandom);
        write_reg(REG_STEPS_PER_DETENT, {noise[CFG_DATA_W-1:SPD_W], spd});
        write_reg(REG_DEBOUNCE_TICKS, deb);
        write_reg(REG_SWITCH_ACTIVE_HIGH, {noise[CFG_DATA_W-1:1], ah});
        write_reg(REG_OUT_OF_RANGE, ~noise);
        cfg_valid <= 1'b0;
        cur_debounce = int'(deb);
    endtask

    task automatic spin(input int n, input logic up);
        for (int i = 0; i < n; i++)
            send_tick(ab_after(cur_ab, up), next_switch(), 1'b0, $urandom_range(0, 7) == 0);
    endtask

    task automatic random_phase(input int n);
        logic [1:0] nab;
        int         pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                spin_up = ~spin_up;
            if (pick < 62)
                nab = ab_after(cur_ab, spin_up);
            else if (pick < 72)
                nab = ab_after(cur_ab, !spin_up);
            else if (pick < 78)
                nab = ~cur_ab;
            else
                nab = cur_ab;
            send_tick(nab, next_switch(), $urandom_range(0, 15) == 0,
                      $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 149) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_calm = ~out_calm;
            stall = out_calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(turns_pending, press_pending, switch_level);
        end
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: one detent up, reported and then taken
        for (int i = 0; i < 4; i++)
            send_tick(ab_after(cur_ab, 1'b1), 1'b1, i == 3, 1'b0);
        send_tick(~cur_ab, 1'b1, 1'b0, 1'b0);   // both pins jump, no step
        for (int i = 0; i < 4; i++)
            send_tick(ab_after(cur_ab, 1'b0), 1'b1, 1'b0, 1'b0);

        // zero steps per detent acts as one, no debounce, polarity flipped
        set_config(4'd0, 8'd0, 1'b1);
        send_tick(cur_ab, 1'b1, 1'b0, 1'b0);
        send_tick(cur_ab, 1'b1, 1'b0, 1'b1);
        send_tick(ab_after(cur_ab, 1'b1), 1'b0, 1'b0, 1'b0);
        send_tick(ab_after(cur_ab, 1'b0), 1'b0, 1'b0, 1'b0);
        send_tick(ab_after(cur_ab, 1'b1), 1'b1, 1'b1, 1'b1);
        send_tick(~cur_ab, 1'b1, 1'b0, 1'b0);

        set_config(4'd2, 8'd5, 1'b0);
        for (int i = 0; i < 6; i++)
            send_tick(ab_after(cur_ab, i < 3), 1'b0, 1'b0, i == 5);

        // drive the count into both limits
        set_config(4'd1, 8'd3, 1'b0);
        spin(135, 1'b1);
        send_tick(cur_ab, next_switch(), 1'b1, 1'b0);
        spin(133, 1'b0);

        set_config(4'd4, 8'd20, 1'b0);
        random_phase(110);
        set_config(4'd8, 8'd255, 1'b1);
        random_phase(320);
        set_config(4'd15, 8'd3, 1'b0);
        random_phase(110);
        set_config(4'd9, 8'd1, 1'b1);
        random_phase(110);
        set_config(4'd3, 8'd0, 1'b0);
        random_phase(110);

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/rotenc_pkg.sv
rtl/rotenc_cfg.sv
rtl/rotenc_quad.sv
rtl/rotenc_switch.sv
rtl/rotary_encoder_with_switch_top.sv
rtl/rotenc_chk.sv
tb/rotary_encoder_with_switch_top_tb.sv
